@@ rtl/fut_pkg.sv @@
// ----------------------------------------------------------------------------
// fut_pkg
// Shared types and constants of the first unique value tracker.
// ----------------------------------------------------------------------------
package fut_pkg;

    // payload widths fixed by the item format
    localparam int VALUE_W = 8;
    localparam int COUNT_W = 2;

    // occurrence count codes, saturating at repeated
    localparam logic [COUNT_W-1:0] COUNT_NONE     = 2'd0;
    localparam logic [COUNT_W-1:0] COUNT_ONCE     = 2'd1;
    localparam logic [COUNT_W-1:0] COUNT_REPEATED = 2'd2;

    // sequencer states, one-hot
    typedef enum logic [5:0] {
        ST_CLEAR    = 6'b000001,
        ST_IDLE     = 6'b000010,
        ST_UPD      = 6'b000100,
        ST_SKIP_ORD = 6'b001000,
        ST_SKIP_CNT = 6'b010000,
        ST_HOLD     = 6'b100000
    } t_state;

endpackage

@@ rtl/fut_if.sv @@
// ----------------------------------------------------------------------------
// fut_if
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface fut_in_if;
    logic                        valid;
    logic                        ready;
    logic [fut_pkg::VALUE_W-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

interface fut_out_if;
    logic                        valid;
    logic                        ready;
    logic                        found;
    logic [fut_pkg::VALUE_W-1:0] first_value;

    modport source (output valid, output found, output first_value, input ready);
    modport sink   (input valid, input found, input first_value, output ready);
endinterface

@@ rtl/fut_ram.sv @@
// ----------------------------------------------------------------------------
// fut_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module fut_ram #(
    parameter int ADDR_W = 8,
    parameter int DATA_W = 8
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [2**ADDR_W];
    logic [DATA_W-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/fut_seq.sv @@
// ----------------------------------------------------------------------------
// fut_seq
// Sequencer: count clearing, count read-modify-write, first-occurrence push and head skip.
// ----------------------------------------------------------------------------
module fut_seq #(
    parameter int KEY_BITS = 8
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    fut_in_if.sink                       i_in,
    fut_out_if.source                    o_out,
    // count memory
    output logic                         o_cnt_we,
    output logic [KEY_BITS-1:0]          o_cnt_waddr,
    output logic [fut_pkg::COUNT_W-1:0]  o_cnt_wdata,
    output logic [KEY_BITS-1:0]          o_cnt_raddr,
    input  logic [fut_pkg::COUNT_W-1:0]  i_cnt_rdata,
    // order memory
    output logic                         o_ord_we,
    output logic [KEY_BITS-1:0]          o_ord_waddr,
    output logic [KEY_BITS-1:0]          o_ord_wdata,
    output logic [KEY_BITS-1:0]          o_ord_raddr,
    input  logic [KEY_BITS-1:0]          i_ord_rdata
);
    import fut_pkg::*;

    localparam int PTR_W = KEY_BITS + 1;
    localparam logic [PTR_W-1:0] DEPTH = PTR_W'(2**KEY_BITS);

    t_state               r_state, n_state;
    logic [KEY_BITS-1:0]  r_clr, n_clr;
    logic [PTR_W-1:0]     r_head, n_head;
    logic [PTR_W-1:0]     r_tail, n_tail;
    logic [KEY_BITS-1:0]  r_key, n_key;
    logic [KEY_BITS-1:0]  r_head_key, n_head_key;
    logic                 r_out_valid, n_out_valid;
    logic                 r_found, n_found;
    logic [VALUE_W-1:0]   r_first, n_first;

    logic                 accept;
    logic                 fin;
    logic                 push;
    logic [PTR_W-1:0]     head_inc;

    assign accept   = i_in.valid && i_in.ready;
    assign head_inc = r_head + PTR_W'(1);
    assign push     = (i_cnt_rdata == COUNT_NONE) && !r_tail[KEY_BITS];

    // the order read always looks one entry past the head
    assign o_ord_raddr = head_inc[KEY_BITS-1:0];
    assign o_ord_waddr = r_tail[KEY_BITS-1:0];
    assign o_ord_wdata = r_key;

    // next-state logic
    always_comb begin
        n_state     = r_state;
        n_clr       = r_clr;
        n_head      = r_head;
        n_tail      = r_tail;
        n_key       = r_key;
        n_head_key  = r_head_key;
        fin         = 1'b0;
        o_cnt_we    = 1'b0;
        o_cnt_waddr = r_key;
        o_cnt_wdata = COUNT_NONE;
        o_cnt_raddr = KEY_BITS'(i_in.value);
        o_ord_we    = 1'b0;

        unique case (r_state)
            ST_CLEAR: begin
                o_cnt_we    = 1'b1;
                o_cnt_waddr = r_clr;
                n_clr       = r_clr + KEY_BITS'(1);
                if (r_clr == '1) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    n_key   = KEY_BITS'(i_in.value);
                    n_state = ST_UPD;
                end
            end
            ST_UPD: begin
                // count saturates at repeated
                if (i_cnt_rdata < COUNT_REPEATED) begin
                    o_cnt_we    = 1'b1;
                    o_cnt_wdata = i_cnt_rdata + COUNT_W'(1);
                end
                // first occurrence goes to the fifo tail
                if (push) begin
                    o_ord_we = 1'b1;
                    n_tail   = r_tail + PTR_W'(1);
                    if (r_head == r_tail) begin
                        n_head_key = r_key;
                    end
                end
                // head key just became repeated
                if ((r_head != r_tail) && (r_head_key == r_key) &&
                    (i_cnt_rdata == COUNT_ONCE)) begin
                    n_head = head_inc;
                    if (head_inc == r_tail) begin
                        fin = 1'b1;
                    end else begin
                        n_state = ST_SKIP_ORD;
                    end
                end else begin
                    fin = 1'b1;
                end
            end
            ST_SKIP_ORD: begin
                n_head_key  = i_ord_rdata;
                o_cnt_raddr = i_ord_rdata;
                n_state     = ST_SKIP_CNT;
            end
            ST_SKIP_CNT: begin
                if (i_cnt_rdata >= COUNT_REPEATED) begin
                    n_head = head_inc;
                    if (head_inc == r_tail) begin
                        fin = 1'b1;
                    end else begin
                        n_state = ST_SKIP_ORD;
                    end
                end else begin
                    fin = 1'b1;
                end
            end
            ST_HOLD: begin
                fin = 1'b1;
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase

        // result register
        n_out_valid = r_out_valid && !o_out.ready;
        n_found     = r_found;
        n_first     = r_first;
        if (fin) begin
            if (!r_out_valid || o_out.ready) begin
                n_out_valid = 1'b1;
                n_found     = (n_head != n_tail);
                n_first     = (n_head != n_tail) ? VALUE_W'(n_head_key) : '0;
                n_state     = ST_IDLE;
            end else begin
                n_state = ST_HOLD;
            end
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr       <= '0;
            r_head      <= '0;
            r_tail      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_key      <= n_key;
        r_head_key <= n_head_key;
        r_found    <= n_found;
        r_first    <= n_first;
    end

    assign i_in.ready        = (r_state == ST_IDLE);
    assign o_out.valid       = r_out_valid;
    assign o_out.found       = r_found;
    assign o_out.first_value = r_first;

    // checks
    a_head_le_tail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_head <= r_tail) else $error("fifo head passed tail");

    a_tail_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tail <= DEPTH) else $error("fifo tail beyond depth");

    a_accept_upd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == ST_UPD)) else $error("accepted item not updated");

    a_not_found_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_found) |-> (r_first == '0))
        else $error("first_value not zero without found");

endmodule

@@ rtl/first_unique_value_tracker.sv @@
// ----------------------------------------------------------------------------
// first_unique_value_tracker
// Reports, after each item, the oldest key seen exactly once so far.
// ----------------------------------------------------------------------------
// sequence: the count is read as the item is accepted and ST_UPD updates it;
//   when the head key turns repeated, ST_SKIP_ORD and ST_SKIP_CNT read each
//   further fifo entry, at most one per key ever pushed; a new item is taken
//   only once the last result is registered, which ST_HOLD delays on a stall
// reset: synchronous; a clearing pass over all 2^KEY_BITS count entries
//   zeroes the count memory, during which no item is accepted
module first_unique_value_tracker #(
    parameter int KEY_BITS = 8
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    fut_in_if.sink    i_in,
    fut_out_if.source o_out
);
    import fut_pkg::*;

    logic                cnt_we;
    logic [KEY_BITS-1:0] cnt_waddr;
    logic [COUNT_W-1:0]  cnt_wdata;
    logic [KEY_BITS-1:0] cnt_raddr;
    logic [COUNT_W-1:0]  cnt_rdata;
    logic                ord_we;
    logic [KEY_BITS-1:0] ord_waddr;
    logic [KEY_BITS-1:0] ord_wdata;
    logic [KEY_BITS-1:0] ord_raddr;
    logic [KEY_BITS-1:0] ord_rdata;

    // sequencer
    fut_seq #(.KEY_BITS(KEY_BITS)) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .o_out       (o_out),
        .o_cnt_we    (cnt_we),
        .o_cnt_waddr (cnt_waddr),
        .o_cnt_wdata (cnt_wdata),
        .o_cnt_raddr (cnt_raddr),
        .i_cnt_rdata (cnt_rdata),
        .o_ord_we    (ord_we),
        .o_ord_waddr (ord_waddr),
        .o_ord_wdata (ord_wdata),
        .o_ord_raddr (ord_raddr),
        .i_ord_rdata (ord_rdata)
    );

    // occurrence counts per key
    fut_ram #(.ADDR_W(KEY_BITS), .DATA_W(COUNT_W)) u_cnt_ram (
        .i_clk   (i_clk),
        .i_we    (cnt_we),
        .i_waddr (cnt_waddr),
        .i_wdata (cnt_wdata),
        .i_raddr (cnt_raddr),
        .o_rdata (cnt_rdata)
    );

    // keys in order of first occurrence
    fut_ram #(.ADDR_W(KEY_BITS), .DATA_W(KEY_BITS)) u_ord_ram (
        .i_clk   (i_clk),
        .i_we    (ord_we),
        .i_waddr (ord_waddr),
        .i_wdata (ord_wdata),
        .i_raddr (ord_raddr),
        .o_rdata (ord_rdata)
    );

endmodule

@@ tb/fut_report_monitor.sv @@
// ----------------------------------------------------------------------------
// fut_report_monitor
// Watches the item and result channels of the first unique value tracker,
// predicts each result from the accepted keys and compares them in order.
// ----------------------------------------------------------------------------
module fut_report_monitor (
    input  logic        i_clk,
    input  logic        i_rst_n,
    fut_in_if           i_in_mon,
    fut_out_if          i_out_mon,
    output int unsigned o_fail_count,
    output int unsigned o_pending
);
    import fut_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int KEY_DEPTH = 1 << VALUE_W;

    typedef struct packed {
        logic               found;
        logic [VALUE_W-1:0] first_value;
    } t_unique_report;

    // model state: per-key occurrence count and keys in first-seen order
    logic [COUNT_W-1:0] occ_count [KEY_DEPTH];
    logic [VALUE_W-1:0] first_seen_q [$];
    t_unique_report     expected_reports [$];

    // add one key to the stream and report the oldest key seen exactly once
    function automatic t_unique_report predict_first_unique(input logic [VALUE_W-1:0] key);
        t_unique_report rep;
        if (occ_count[key] == COUNT_NONE) begin
            first_seen_q.push_back(key);
        end
        if (occ_count[key] != COUNT_REPEATED) begin
            occ_count[key] = occ_count[key] + 1'b1;
        end
        // drop repeated keys off the head
        while (first_seen_q.size() > 0 && occ_count[first_seen_q[0]] == COUNT_REPEATED) begin
            void'(first_seen_q.pop_front());
        end
        rep.found       = (first_seen_q.size() > 0);
        rep.first_value = rep.found ? first_seen_q[0] : '0;
        return rep;
    endfunction

    // compare results, then record the expectation for a new item
    always @(posedge i_clk) begin
        t_unique_report want;
        if (!i_rst_n) begin
            for (int k = 0; k < KEY_DEPTH; k++) begin
                occ_count[k] = COUNT_NONE;
            end
            first_seen_q.delete();
            expected_reports.delete();
            o_fail_count = 0;
        end else begin
            if (i_out_mon.valid === 1'b1 && i_out_mon.ready === 1'b1) begin
                if (expected_reports.size() == 0) begin
                    $display("%0t: unexpected result: expected none, actual found=%0d value=%0d",
                             $time, i_out_mon.found, i_out_mon.first_value);
                    o_fail_count = o_fail_count + 1;
                end else begin
                    want = expected_reports.pop_front();
                    if (i_out_mon.found !== want.found) begin
                        $display("%0t: found mismatch: expected %0d, actual %0d",
                                 $time, want.found, i_out_mon.found);
                        o_fail_count = o_fail_count + 1;
                    end
                    if (i_out_mon.first_value !== want.first_value) begin
                        $display("%0t: first_value mismatch: expected %0d, actual %0d",
                                 $time, want.first_value, i_out_mon.first_value);
                        o_fail_count = o_fail_count + 1;
                    end
                end
            end
            if (i_in_mon.valid === 1'b1 && i_in_mon.ready === 1'b1) begin
                expected_reports.push_back(predict_first_unique(i_in_mon.value));
            end
        end
        o_pending = expected_reports.size();
    end

endmodule

@@ tb/first_unique_value_tracker_tb.sv @@
// ----------------------------------------------------------------------------
// first_unique_value_tracker_tb
// Feeds keys into the tracker with random gaps and result stalls: a directed
// run over the repeat and skip cases, then a random stream that brings every
// key in gradually so the order fifo fills up and drains.
// ----------------------------------------------------------------------------
module first_unique_value_tracker_tb;
    import fut_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS   = 1126;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 10;

    logic        i_clk;
    logic        i_rst_n;
    int unsigned fail_count;
    int unsigned pending_count;
    int unsigned idle_cycles;
    bit          send_no_gap;
    bit          sink_no_stall;
    int          unused_keys;
    logic [COUNT_W-1:0] sent_count [1 << VALUE_W];

    fut_in_if  in_ch ();
    fut_out_if out_ch ();

    first_unique_value_tracker #(
        .KEY_BITS (VALUE_W)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    fut_report_monitor u_monitor (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_mon     (in_ch),
        .i_out_mon    (out_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending_count)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // watchdog on cycles with no handshake on either channel
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            idle_cycles <= 0;
        end else if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
            (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)) begin
            idle_cycles <= 0;
        end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired with %0d results outstanding",
                     $time, pending_count);
            $display("Regression FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // result side: random stalls, with runs of none
    initial begin : result_sink
        int stall;
        sink_no_stall = 1'b0;
        out_ch.ready  = 1'b0;
        @(negedge i_clk);
        forever begin
            stall = sink_no_stall ? 0 : $urandom_range(0, 5);
            if (stall > 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            out_ch.ready <= 1'b1;
            @(posedge i_clk);
            while (!(out_ch.valid === 1'b1 && out_ch.ready === 1'b1)) @(posedge i_clk);
            @(negedge i_clk);
            if ($urandom_range(0, 39) == 0) sink_no_stall = !sink_no_stall;
        end
    end

    // send one key, called at a falling edge and returns at one
    task automatic send_key(input logic [VALUE_W-1:0] key);
        int gap;
        gap = send_no_gap ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.value <= key;
        @(posedge i_clk);
        while (!(in_ch.valid === 1'b1 && in_ch.ready === 1'b1)) @(posedge i_clk);
        @(negedge i_clk);
        // track which keys are new, once-seen or repeated
        if (sent_count[key] == COUNT_NONE) unused_keys--;
        if (sent_count[key] != COUNT_REPEATED) sent_count[key] = sent_count[key] + 1'b1;
        if ($urandom_range(0, 39) == 0) send_no_gap = !send_no_gap;
    endtask

    // stimulus and verdict
    initial begin : key_source
        logic [VALUE_W-1:0] key;
        int roll;
        in_ch.valid = 1'b0;
        in_ch.value = '0;
        i_rst_n     = 1'b0;
        send_no_gap = 1'b0;
        unused_keys = 1 << VALUE_W;
        for (int k = 0; k < (1 << VALUE_W); k++) sent_count[k] = COUNT_NONE;
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        // extremes, repeats, saturation and the empty report
        send_key(8'd0);
        send_key(8'd255);
        send_key(8'd0);
        send_key(8'd0);
        send_key(8'd255);
        send_key(8'd255);
        // walking ones, then repeats behind the head and a multi-entry skip
        for (int b = 0; b < VALUE_W; b++) send_key(VALUE_W'(1) << b);
        send_key(8'd1);
        send_key(8'd4);
        send_key(8'd8);
        send_key(8'd2);
        send_key(8'd16);
        send_key(8'd32);
        send_key(8'd64);
        send_key(8'd128);
        send_key(8'hAA);
        send_key(8'h55);

        // random: new keys trickle in, most others hit once-seen keys
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            roll = $urandom_range(0, 99);
            key  = VALUE_W'($urandom_range(0, (1 << VALUE_W) - 1));
            if (roll < 24 && unused_keys > 0) begin
                while (sent_count[key] != COUNT_NONE) key = key + 1'b1;
            end else if (roll < 90) begin
                for (int t = 0; t < 8 && sent_count[key] != COUNT_ONCE; t++) begin
                    key = VALUE_W'($urandom_range(0, (1 << VALUE_W) - 1));
                end
            end
            send_key(key);
        end
        in_ch.valid <= 1'b0;

        // drain outstanding results, then a short settle
        while (pending_count != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/fut_pkg.sv
rtl/fut_if.sv
rtl/fut_ram.sv
rtl/fut_seq.sv
rtl/first_unique_value_tracker.sv
tb/fut_report_monitor.sv
tb/first_unique_value_tracker_tb.sv
